>>> src/irrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irrb_pkg
// types and constants shared by the input record/replay buffer
// ----------------------------------------------------------------------------
package irrb_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_RECORD = 3'd1,
		MODE_PLAY   = 3'd2,
		MODE_BREAK  = 3'd3,
		MODE_STEP   = 3'd4,
		MODE_STOP   = 3'd5
	} mode_t;

	// run state, one-hot
	typedef enum logic [2:0] {
		ST_INACTIVE  = 3'b001,
		ST_RECORDING = 3'b010,
		ST_PLAYING   = 3'b100
	} run_state_t;

	// encoded run state as reported on the output
	localparam logic [1:0] MS_INACTIVE  = 2'd0;
	localparam logic [1:0] MS_RECORDING = 2'd1;
	localparam logic [1:0] MS_PLAYING   = 2'd2;

	// configuration register
	localparam int          LIMIT_BITS     = 13;
	localparam logic [12:0] LIMIT_RESET    = 13'd4096;
	localparam logic        REG_LIMIT_IDX  = 1'b0;

	// field widths
	localparam int DATA_BITS  = 64;
	localparam int MODE_BITS  = 3;
	localparam int OUSER_BITS = 6;

	function automatic logic [1:0] encode_state(input run_state_t st);
		logic [1:0] code;
		case (st)
			ST_RECORDING: code = MS_RECORDING;
			ST_PLAYING:   code = MS_PLAYING;
			default:      code = MS_INACTIVE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

>>> src/input_record_replay_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// input_record_replay_buffer_core
// records live frame words into a frame store and replays them in a loop
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                | contents
//  s_axis    | in        | tvalid/tready            | tuser: mode, tdata: frame_input
//  m_axis    | out       | tvalid/tready            | tuser: flags and state, tdata: frame_out
//  apb       | in/out    | psel/penable/pwrite      | record_limit at byte address 0
//
// one request per cycle sustained while m_axis does not stall; a request passes
// stage 1 (control update, frame store read or write issued) and then the
// output register (read data or the live word selected)
// the frame store has at most one read or write per request, which sets the rate
// arst_n clears control state, sets limit_q to LIMIT_RESET; the frame store is not
// cleared, only entries written by the current recording are ever replayed
// a stall on m_axis holds the output register; stage 1 still takes one request
// if it is empty, then input ready drops until the output side moves
// ----------------------------------------------------------------------------
module input_record_replay_buffer_core
	import irrb_pkg::*;
#(
	parameter int DEPTH     = 4096,
	parameter int WORD_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [DATA_BITS-1:0]  s_axis_tdata,  // [63:0] frame_input
	input  wire logic [MODE_BITS-1:0]  s_axis_tuser,  // [2:0] mode

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [DATA_BITS-1:0]       m_axis_tdata,  // [63:0] frame_out
	// [0] replayed, [1] reload_request, [2] just_paused, [4:3] mode_state, [5] is_paused
	output logic [OUSER_BITS-1:0]      m_axis_tuser,

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

	// configuration
	logic [LIMIT_BITS-1:0] limit_q;
	logic [CW-1:0]         eff_limit;

	// control state
	run_state_t   state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic          paused_q;
	logic          armed_q;
	logic [AW-1:0] brk_q;

	// frame store
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_s1;

	// stage 1
	logic                 valid_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic                 rep_s1;
	logic                 reload_s1;
	logic                 jp_s1;
	logic [1:0]           ms_s1;
	logic                 paused_s1;

	// output register
	logic                 valid_s2;
	logic [WORD_BITS-1:0] fout_s2;
	logic [OUSER_BITS-1:0] user_s2;

	// request decode
	logic                 accept;
	logic                 adv_s1;
	mode_t                mode;
	logic [WORD_BITS-1:0] live;
	logic                 rec_tick;
	logic                 play_tick;
	logic [CW-1:0]        count_inc;
	logic [AW-1:0]        pos_eff;
	logic [CW-1:0]        pos_inc;
	logic [AW-1:0]        pos_next;
	logic                 wr_en;
	logic                 break_hit;
	logic [AW-1:0]        step_pos;

	// next control state
	run_state_t    state_d;
	logic [CW-1:0] count_d;
	logic [AW-1:0] pos_d;
	logic          paused_d;
	logic          armed_d;
	logic [AW-1:0] brk_d;

	// ------------------------------------------------------------------
	// apb register
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT_IDX) begin
			limit_q <= pwdata[LIMIT_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LIMIT_IDX) begin
			prdata = 32'(limit_q);
		end
	end

	// limit clamped to 1..DEPTH
	always_comb begin
		if (limit_q == '0) begin
			eff_limit = CW'(1);
		end else if (LW'(limit_q) > LW'(DEPTH)) begin
			eff_limit = CW'(DEPTH);
		end else begin
			eff_limit = CW'(limit_q);
		end
	end

	// ------------------------------------------------------------------
	// handshake: stage 1 moves when empty, both when the output can take a request
	// ------------------------------------------------------------------
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign mode = mode_t'(s_axis_tuser);
	assign live = s_axis_tdata[WORD_BITS-1:0];

	// ------------------------------------------------------------------
	// tick work: record write or replay read, position wrap, breakpoint
	// ------------------------------------------------------------------
	assign rec_tick  = (mode == MODE_TICK) && (state_q == ST_RECORDING);
	assign play_tick = (mode == MODE_TICK) && (state_q == ST_PLAYING) && !paused_q
		&& (count_q != '0);

	assign count_inc = count_q + CW'(1);
	assign wr_en     = accept && rec_tick && (count_q < CW'(DEPTH));

	// a position beyond the recording restarts from the first frame
	assign pos_eff   = (CW'(pos_q) >= count_q) ? '0 : pos_q;
	assign pos_inc   = CW'(pos_eff) + CW'(1);
	assign pos_next  = (pos_inc >= count_q) ? '0 : pos_inc[AW-1:0];
	assign break_hit = armed_q && (brk_q == pos_next);

	// step target: one frame past the current position, modulo the count
	assign step_pos  = (CW'(pos_q) + CW'(1) == count_q) ? '0 : AW'(CW'(pos_q) + CW'(1));

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pos_d    = pos_q;
		paused_d = paused_q;
		armed_d  = armed_q;
		brk_d    = brk_q;
		case (mode)
			MODE_TICK: begin
				if (rec_tick) begin
					count_d = count_inc;
					if (count_inc >= eff_limit) begin
						state_d = ST_INACTIVE;
					end
				end else if (play_tick) begin
					pos_d = pos_next;
					if (break_hit) begin
						paused_d = 1'b1;
						armed_d  = 1'b0;
					end
				end
			end
			MODE_RECORD: begin
				if (state_q == ST_INACTIVE) begin
					state_d = ST_RECORDING;
					count_d = '0;
				end
			end
			MODE_PLAY: begin
				pos_d   = '0;
				state_d = ST_PLAYING;
			end
			MODE_BREAK: begin
				if (state_q == ST_PLAYING) begin
					armed_d = 1'b1;
				end
			end
			MODE_STEP: begin
				if (state_q == ST_PLAYING) begin
					armed_d  = 1'b1;
					paused_d = 1'b0;
					brk_d    = (count_q == '0) ? '0 : step_pos;
				end
			end
			MODE_STOP: begin
				state_d  = ST_INACTIVE;
				armed_d  = 1'b0;
				paused_d = 1'b0;
				pos_d    = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INACTIVE;
			count_q  <= '0;
			pos_q    <= '0;
			paused_q <= 1'b0;
			armed_q  <= 1'b0;
			brk_q    <= '0;
		end else if (accept) begin
			state_q  <= state_d;
			count_q  <= count_d;
			pos_q    <= pos_d;
			paused_q <= paused_d;
			armed_q  <= armed_d;
			brk_q    <= brk_d;
		end
	end

	// ------------------------------------------------------------------
	// frame store, at most one access per request, read data registered
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= live;
		end
		if (accept && play_tick) begin
			rdata_s1 <= mem[pos_eff];
		end
	end

	// ------------------------------------------------------------------
	// stage 1: flags of the accepted request, waiting on the read data
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// command requests answer with a zero word and no flags
			word_s1   <= (mode == MODE_TICK) ? live : '0;
			rep_s1    <= play_tick;
			reload_s1 <= play_tick && (pos_next == '0);
			jp_s1     <= play_tick && break_hit;
			ms_s1     <= encode_state(state_d);
			paused_s1 <= paused_d;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			fout_s2 <= rep_s1 ? rdata_s1 : word_s1;
			user_s2 <= {paused_s1, ms_s1, jp_s1, reload_s1, rep_s1};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = DATA_BITS'(fout_s2);
	assign m_axis_tuser  = user_s2;

endmodule
`default_nettype wire

>>> tb/tb_input_record_replay_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_input_record_replay_buffer_core
// self-checking bench for the frame record/replay buffer: a queue-fed driver
// sends mode/word requests and a scoreboard model of the recorder predicts
// each result at acceptance. a monitor compares every output field in order.
// directed requests come first, then random record/playback sessions under
// several record limits, with one long recording in the middle
// ----------------------------------------------------------------------------
module tb_input_record_replay_buffer_core;
	import irrb_pkg::*;

	localparam int          CLK_PERIOD     = 10;
	localparam int          FRAME_DEPTH    = 4096;
	localparam int          WORD_WIDTH     = 64;
	localparam int          LATENCY_SLACK  = 4;      // two-stage pipe plus margin
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          MAX_REPORTS    = 100;
	localparam int          RANDOM_ITEMS   = 1200;
	localparam int          LONG_RECORD    = 200;    // frames in the long recording
	localparam int          QUIET_TAIL     = 150;    // last requests run without idling
	localparam logic [2:0]  LIMIT_ADDR     = 3'(4 * int'(REG_LIMIT_IDX));
	localparam logic [31:0] LIMIT_MASK     = 32'h0000_1FFF;
	localparam logic [63:0] ALL_ONES       = '1;
	localparam logic [63:0] ALL_ZEROS      = '0;
	// mode codes the block does not define; they must answer like a command
	localparam logic [2:0]  MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;

	// one request as it goes onto s_axis
	typedef struct packed {
		logic [2:0]            mode;
		logic [DATA_BITS-1:0]  word;
	} frame_req_t;

	// one result as it comes off m_axis
	typedef struct packed {
		logic [DATA_BITS-1:0]  frame_out;
		logic                  replayed;
		logic                  reload_request;
		logic                  just_paused;
		logic [1:0]            mode_state;
		logic                  is_paused;
	} frame_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [DATA_BITS-1:0]   s_axis_tdata  = '0;   // [63:0] frame_input
	logic [MODE_BITS-1:0]   s_axis_tuser  = '0;   // [2:0] mode

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [DATA_BITS-1:0]   m_axis_tdata;         // [63:0] frame_out
	// [0] replayed, [1] reload_request, [2] just_paused, [4:3] mode_state, [5] is_paused
	logic [OUSER_BITS-1:0]  m_axis_tuser;

	logic                   psel          = 1'b0;
	logic                   penable       = 1'b0;
	logic                   pwrite        = 1'b0;
	logic [2:0]             paddr         = '0;
	logic [31:0]            pwdata        = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// request and result queues
	frame_req_t             pending_reqs[$];
	frame_result_t          expected_frames[$];

	// bench control
	bit                     idle_on       = 1'b1;
	int                     send_gap      = 0;
	int                     stall_left    = 0;
	int                     quiet_cycles  = 0;
	int                     fail_count    = 0;
	int                     queued_items  = 0;

	// scoreboard copy of the recorder state, matching its reset values
	logic [DATA_BITS-1:0]   frame_mem [FRAME_DEPTH];
	logic [1:0]             run_code      = MS_INACTIVE;
	int unsigned            rec_count     = 0;
	int unsigned            play_pos      = 0;
	int unsigned            brk_pos       = 0;
	logic                   paused        = 1'b0;
	logic                   brk_armed     = 1'b0;
	logic [LIMIT_BITS-1:0]  limit_reg     = LIMIT_RESET;

	always #(CLK_PERIOD / 2) clk = ~clk;

	input_record_replay_buffer_core #(
		.DEPTH     (FRAME_DEPTH),
		.WORD_BITS (WORD_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ------------------------------------------------------------------------
	// recorder model: advances the scoreboard state by one accepted request
	// and queues the result the block must give for it
	// ------------------------------------------------------------------------
	task automatic record_or_replay(input logic [2:0] mode, input logic [DATA_BITS-1:0] live);
		frame_result_t res;
		int unsigned   lim;
		res = '0;
		// limit register clamped into 1..depth, so 0 records a single frame
		if (limit_reg < 1)
			lim = 1;
		else if (limit_reg > FRAME_DEPTH)
			lim = FRAME_DEPTH;
		else
			lim = limit_reg;
		case (mode)
			MODE_TICK: begin
				res.frame_out = live;
				if (run_code == MS_RECORDING) begin
					if (rec_count < FRAME_DEPTH)
						frame_mem[rec_count] = live;
					rec_count++;
					// a lowered limit stops recording right after this write
					if (rec_count >= lim)
						run_code = MS_INACTIVE;
				end else if (run_code == MS_PLAYING && !paused && rec_count != 0) begin
					if (play_pos >= rec_count)
						play_pos = 0;
					res.frame_out = frame_mem[play_pos];
					res.replayed = 1'b1;
					play_pos++;
					if (play_pos >= rec_count)
						play_pos = 0;
					// wrap back to the first frame asks for a reload
					if (play_pos == 0)
						res.reload_request = 1'b1;
					if (brk_armed && brk_pos == play_pos) begin
						paused = 1'b1;
						brk_armed = 1'b0;
						res.just_paused = 1'b1;
					end
				end
				// empty recording, paused or inactive: live word passes through
			end
			MODE_RECORD: begin
				// ignored unless inactive
				if (run_code == MS_INACTIVE) begin
					run_code = MS_RECORDING;
					rec_count = 0;
				end
			end
			MODE_PLAY: begin
				// pause and breakpoint survive a restart of playback
				play_pos = 0;
				run_code = MS_PLAYING;
			end
			MODE_BREAK: begin
				if (run_code == MS_PLAYING)
					brk_armed = 1'b1;
			end
			MODE_STEP: begin
				if (run_code == MS_PLAYING) begin
					brk_armed = 1'b1;
					paused = 1'b0;
					brk_pos = (rec_count == 0) ? 0 : (play_pos + 1) % rec_count;
				end
			end
			MODE_STOP: begin
				run_code = MS_INACTIVE;
				brk_armed = 1'b0;
				paused = 1'b0;
				play_pos = 0;
			end
			default: begin
				// unused modes change nothing
			end
		endcase
		res.mode_state = run_code;
		res.is_paused = paused;
		expected_frames.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: presents queued requests on s_axis, predicts each one on accept
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_requests
		frame_req_t req;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				record_or_replay(s_axis_tuser, s_axis_tdata);
			// a request that is still waiting is held unchanged
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= req.mode;
					s_axis_tdata <= req.word;
					// now and then a random idle gap after this request
					if (idle_on && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each accepted result against the oldest prediction and
	// stalls the output side in random bursts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_frames.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$error("result with nothing pending: frame_out %0h, tuser %0h",
							m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_frames.pop_front();
					check_field("frame_out", want.frame_out, m_axis_tdata);
					check_field("replayed", want.replayed, m_axis_tuser[0]);
					check_field("reload_request", want.reload_request, m_axis_tuser[1]);
					check_field("just_paused", want.just_paused, m_axis_tuser[2]);
					check_field("mode_state", want.mode_state, m_axis_tuser[4:3]);
					check_field("is_paused", want.is_paused, m_axis_tuser[5]);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				// random-length stall that starts here
				stall_left = $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without apb activity or any accepted request or result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_req(input logic [2:0] mode, input logic [DATA_BITS-1:0] word);
		frame_req_t req;
		req.mode = mode;
		req.word = word;
		pending_reqs.push_back(req);
		queued_items++;
	endtask

	// full random words, with the all-ones and all-zeros words mixed in
	function automatic logic [DATA_BITS-1:0] random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return ALL_ONES;
		if (pick == 1)
			return ALL_ZEROS;
		return {$urandom, $urandom};
	endfunction

	// mostly small limits, now and then the largest and the out-of-range one
	function automatic logic [31:0] random_limit();
		logic [31:0] upper;
		int          pick;
		upper = $urandom & ~LIMIT_MASK;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return upper | LIMIT_MASK;
		if (pick == 1)
			return 32'(LIMIT_RESET);
		return upper | 32'($urandom_range(0, 15));
	endfunction

	// stream side drained and the pipe given time to empty
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_frames.size() != 0)
			@(negedge clk);
		repeat (LATENCY_SLACK) @(negedge clk);
	endtask

	// apb write of the record limit, then a read back of it
	task automatic write_limit(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		limit_reg = value[LIMIT_BITS-1:0];
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", 64'(limit_reg), 64'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// one record/playback session with random content and some noise
	task automatic queue_session();
		int rec_len;
		int play_len;
		int pick;
		push_req(MODE_RECORD, random_word());
		rec_len = $urandom_range(0, 10);
		repeat (rec_len) push_req(MODE_TICK, random_word());
		// now and then leave the recording open across a limit change
		if ($urandom_range(0, 5) == 0)
			return;
		if ($urandom_range(0, 3) == 0)
			push_req(MODE_STOP, random_word());
		push_req(MODE_PLAY, random_word());
		play_len = $urandom_range(4, 40);
		repeat (play_len) begin
			pick = $urandom_range(0, 99);
			if (pick < 68)
				push_req(MODE_TICK, random_word());
			else if (pick < 76)
				push_req(MODE_BREAK, random_word());
			else if (pick < 86)
				push_req(MODE_STEP, random_word());
			else if (pick < 90)
				push_req(MODE_PLAY, random_word());
			else if (pick < 93)
				push_req(MODE_STOP, random_word());
			else
				push_req(3'($urandom_range(0, 7)), random_word());
		end
		if ($urandom_range(0, 4) != 0)
			push_req(MODE_STOP, random_word());
	endtask

	task automatic run_sessions(input int target, input bit vary_idle);
		while (queued_items < target) begin
			if (vary_idle)
				idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
				0, 1: begin
					// block idle before the limit changes
					wait_idle();
					write_limit(random_limit());
				end
				2: wait_idle();    // sender holds until every result is in
				default: begin
				end
			endcase
			queue_session();
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin : run_test
		int target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: limit of three, junk in the unused register bits
		write_limit(32'hABCD_0003);
		push_req(MODE_TICK, ALL_ONES);          // inactive pass-through
		push_req(MODE_BREAK, random_word());    // ignored, not playing
		push_req(MODE_STEP, random_word());     // ignored, not playing
		push_req(MODE_UNUSED_LO, ALL_ONES);
		push_req(MODE_UNUSED_HI, ALL_ONES);
		push_req(MODE_PLAY, random_word());     // playback of an empty recording
		push_req(MODE_TICK, random_word());     // live word, not replayed
		push_req(MODE_STEP, random_word());     // empty: breakpoint at first frame
		push_req(MODE_STOP, random_word());
		push_req(MODE_RECORD, random_word());
		push_req(MODE_RECORD, random_word());   // ignored, already recording
		push_req(MODE_TICK, ALL_ONES);
		push_req(MODE_TICK, ALL_ZEROS);
		push_req(MODE_TICK, random_word());     // limit reached here
		push_req(MODE_PLAY, random_word());
		repeat (3) push_req(MODE_TICK, random_word());  // wrap on the third
		push_req(MODE_BREAK, random_word());    // arm at next wrap
		repeat (3) push_req(MODE_TICK, random_word());  // pauses at the wrap
		push_req(MODE_TICK, random_word());     // paused pass-through
		push_req(MODE_STEP, random_word());     // one frame
		push_req(MODE_TICK, random_word());
		push_req(MODE_PLAY, random_word());     // restart keeps the pause
		push_req(MODE_STOP, random_word());
		wait_idle();

		// limit of zero acts as one
		write_limit(32'h0000_0000);
		push_req(MODE_RECORD, random_word());
		repeat (2) push_req(MODE_TICK, random_word());
		push_req(MODE_PLAY, random_word());
		repeat (3) push_req(MODE_TICK, random_word());  // reload on every frame
		push_req(MODE_STOP, random_word());
		wait_idle();
		write_limit(32'h0000_0001);

		// random sessions, first half
		run_sessions(RANDOM_ITEMS / 2, 1'b1);

		// long recording under an out-of-range limit, then a whole loop
		wait_idle();
		write_limit(($urandom & ~LIMIT_MASK) | LIMIT_MASK);
		push_req(MODE_RECORD, random_word());
		repeat (LONG_RECORD) push_req(MODE_TICK, random_word());
		push_req(MODE_PLAY, random_word());
		repeat (LONG_RECORD + 8) push_req(MODE_TICK, random_word());
		push_req(MODE_STOP, random_word());
		wait_idle();
		write_limit(32'(LIMIT_RESET));

		// random sessions, second half; the tail runs without any idling
		target = queued_items + RANDOM_ITEMS / 2;
		run_sessions(target - QUIET_TAIL, 1'b1);
		idle_on = 1'b0;
		run_sessions(target, 1'b0);

		wait_idle();
		if (fail_count == 0 && expected_frames.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
